// ===== design/lrcs_pkg.sv =====
// Shared types, register codes and constants for the LED ring comet spinner.
package lrcs_pkg;

    localparam int unsigned RING_LIMIT = 64;
    localparam int unsigned DIV_W      = 32;
    localparam int unsigned DVS_W      = 16;
    localparam int unsigned DIV_STEPS  = DIV_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_STOP   = 2'd1,
        OP_UPDATE = 2'd2,
        OP_RENDER = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_LED_COUNT    = 3'd0,
        REG_STEP_PERIOD  = 3'd1,
        REG_CLOCKWISE    = 3'd2,
        REG_TAIL_LENGTH  = 3'd3,
        REG_TAIL_FALLOFF = 3'd4,
        REG_COLOR_RED    = 3'd5,
        REG_COLOR_GREEN  = 3'd6,
        REG_COLOR_BLUE   = 3'd7
    } reg_idx_t;

    localparam logic [6:0]  RST_LED_COUNT    = 7'd16;
    localparam logic [15:0] RST_STEP_PERIOD  = 16'd100;
    localparam logic        RST_CLOCKWISE    = 1'b1;
    localparam logic [7:0]  RST_TAIL_LENGTH  = 8'd4;
    localparam logic [7:0]  RST_TAIL_FALLOFF = 8'd60;
    localparam logic [7:0]  RST_COLOR        = 8'd255;
    localparam logic [7:0]  FULL_BRIGHT      = 8'd255;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] now_ms;
    } cmd_item_t;

    typedef struct packed {
        logic [5:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pix_item_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
        logic [DVS_W-1:0]   remainder;
    } div_rsp_t;

    // Exact floor(x / 255) for any product of two 8-bit values.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return sum[15:8];
    endfunction

endpackage

// ===== design/lrcs_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
module lrcs_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrcs_pkg::div_req_t   req,
    output lrcs_pkg::div_rsp_t   rsp
);

    logic [lrcs_pkg::DIV_CNT_W-1:0] count_reg, count_next;
    logic                           done_reg, done_next;
    logic [lrcs_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [lrcs_pkg::DVS_W-1:0]     rem_reg, rem_next;
    logic [lrcs_pkg::DVS_W-1:0]     dvs_reg, dvs_next;
    logic [lrcs_pkg::DVS_W:0]       shifted;
    logic                           fits;

    always_comb
    begin
        shifted    = {rem_reg, quo_reg[lrcs_pkg::DIV_W-1]};
        fits       = shifted >= {1'b0, dvs_reg};
        count_next = count_reg;
        done_next  = 1'b0;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (req.start)
        begin
            count_next = lrcs_pkg::DIV_CNT_W'(lrcs_pkg::DIV_STEPS);
            quo_next   = req.dividend;
            rem_next   = '0;
            dvs_next   = req.divisor;
        end
        else if (count_reg != '0)
        begin
            // The partial remainder stays below the divisor, so it fits DVS_W bits.
            rem_next   = fits ? lrcs_pkg::DVS_W'(shifted - {1'b0, dvs_reg})
                              : shifted[lrcs_pkg::DVS_W-1:0];
            quo_next   = {quo_reg[lrcs_pkg::DIV_W-2:0], fits};
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == lrcs_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== design/led_ring_comet_spinner.sv =====
// Top level of the LED ring comet spinner: sequencer, state and pixel output.
//
//  Channel | Direction | Handshake              | Item
//  --------+-----------+------------------------+-------------------------------
//  cmd     | in        | cmd_valid / cmd_stall  | operation, now_ms
//  pix     | out       | pix_valid / pix_stall  | pixel_index, rgb, last_pixel
//  cfg     | in        | cfg_we (no wait)       | cfg_index, cfg_data
//
// Start and stop finish on acceptance, as does an update or render with nothing to do.
// An update with at least one period elapsed takes three passes of the shared divider:
// the step count, the head modulo ring size and the steps modulo ring size; the time
// base advances between the first two. A render takes two divider passes, head and
// tail start modulo ring size, then a dim, a multiply and an emit step per pixel. A
// stall on a pixel overlaps the next pixel's dim and multiply steps, but not its emit.
// Reset clears the comet state and loads the documented register defaults.
// The command channel is stalled from acceptance of an item until its work is done.
module led_ring_comet_spinner
#(
    parameter int unsigned MAX_LEDS = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  lrcs_pkg::cmd_item_t    cmd,
    output logic                   pix_valid,
    input  logic                   pix_stall,
    output lrcs_pkg::pix_item_t    pix,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data
);

    // The ring never exceeds the pixel_index range, nor the configured limit.
    localparam int unsigned RING_MAX_I = (MAX_LEDS < lrcs_pkg::RING_LIMIT) ?
                                         MAX_LEDS : lrcs_pkg::RING_LIMIT;
    localparam logic [6:0]  RING_MAX   = 7'(RING_MAX_I);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_STEPS  = 10'b00_0000_0010,
        S_TIME   = 10'b00_0000_0100,
        S_HMOD   = 10'b00_0000_1000,
        S_SMOD   = 10'b00_0001_0000,
        S_RHEAD  = 10'b00_0010_0000,
        S_RSTART = 10'b00_0100_0000,
        S_PDIM   = 10'b00_1000_0000,
        S_PMUL   = 10'b01_0000_0000,
        S_PEMIT  = 10'b10_0000_0000
    } state_t;

    // Configuration registers.
    logic [6:0]  led_count_reg;
    logic [15:0] period_reg;
    logic        clockwise_reg;
    logic [7:0]  tail_len_reg;
    logic [7:0]  falloff_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    // Comet state and sequencer.
    state_t      state_reg, state_next;
    logic        running_reg, running_next;
    logic [5:0]  head_reg, head_next;
    logic [31:0] last_reg, last_next;
    logic [5:0]  pix_cnt_reg, pix_cnt_next;
    logic        pix_valid_reg, pix_valid_next;

    // Working registers, no reset needed.
    logic [15:0]          steps_reg, steps_next;
    logic [5:0]           hmod_reg, hmod_next;
    logic [5:0]           r0_reg, r0_next;
    logic [7:0]           dim_reg, dim_next;
    logic [15:0]          prod_r_reg, prod_g_reg, prod_b_reg;
    lrcs_pkg::pix_item_t  pix_reg, pix_next;

    lrcs_pkg::div_req_t   div_req;
    lrcs_pkg::div_rsp_t   div_rsp;

    // Derived values. The user changes configuration only while idle (not enforced
    // by the block), so these hold steady for the whole of an item.
    logic [6:0]  ring_n;
    logic [7:0]  tail_eff;
    logic [7:0]  lit_len;
    logic [7:0]  i_start;
    logic [31:0] elapsed;
    logic        cmd_fire;
    logic        upd_go;
    logic        rnd_go;
    logic        pix_free;
    logic [31:0] advance;
    logic [6:0]  sum_cw;
    logic [6:0]  new_head;
    logic [5:0]  smod;
    logic [6:0]  behind;
    logic [6:0]  off;
    logic [7:0]  tail_idx;
    logic [15:0] fall_prod;
    logic        lit;

    lrcs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        ring_n   = (led_count_reg > RING_MAX) ? RING_MAX : led_count_reg;
        tail_eff = (tail_len_reg == 8'd0) ? 8'd1 : tail_len_reg;
        // Only the last ring_n tail positions can survive the overwriting, and they
        // land on distinct pixels.
        lit_len  = (tail_eff > {1'b0, ring_n}) ? {1'b0, ring_n} : tail_eff;
        i_start  = tail_eff - lit_len;
        elapsed  = cmd.now_ms - last_reg;
        cmd_fire = cmd_valid && !cmd_stall;
        upd_go   = running_reg && (ring_n != 7'd0) && (period_reg != 16'd0)
                   && (elapsed >= {16'd0, period_reg});
        rnd_go   = running_reg && (ring_n != 7'd0);
        pix_free = !pix_valid_reg || !pix_stall;
    end

    // Head arithmetic for the end of an update.
    always_comb
    begin
        smod   = div_rsp.remainder[5:0];
        sum_cw = {1'b0, hmod_reg} + {1'b0, smod};
        if (clockwise_reg)
        begin
            new_head = (sum_cw >= ring_n) ? sum_cw - ring_n : sum_cw;
        end
        else
        begin
            new_head = (hmod_reg >= smod) ? {1'b0, hmod_reg} - {1'b0, smod}
                                          : {1'b0, hmod_reg} + ring_n - {1'b0, smod};
        end
    end

    // Per-pixel tail lookup: distance behind the head, then the one tail index
    // in the surviving window that lands on this pixel.
    always_comb
    begin
        behind = (hmod_reg >= pix_cnt_reg) ? {1'b0, hmod_reg} - {1'b0, pix_cnt_reg}
                                           : {1'b0, hmod_reg} + ring_n - {1'b0, pix_cnt_reg};
        off  = (behind >= {1'b0, r0_reg}) ? behind - {1'b0, r0_reg}
                                          : behind + ring_n - {1'b0, r0_reg};
        lit       = {1'b0, off} < lit_len;
        tail_idx  = i_start + {1'b0, off};
        fall_prod = {8'd0, tail_idx} * {8'd0, falloff_reg};
    end

    always_comb
    begin
        advance = {16'd0, steps_reg} * {16'd0, period_reg};
    end

    always_comb
    begin
        state_next     = state_reg;
        running_next   = running_reg;
        head_next      = head_reg;
        last_next      = last_reg;
        pix_cnt_next   = pix_cnt_reg;
        pix_valid_next = pix_valid_reg && pix_stall;
        steps_next     = steps_reg;
        hmod_next      = hmod_reg;
        r0_next        = r0_reg;
        dim_next       = dim_reg;
        pix_next       = pix_reg;
        div_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (lrcs_pkg::op_t'(cmd.operation))
                        lrcs_pkg::OP_START:
                        begin
                            running_next = 1'b1;
                            head_next    = '0;
                            last_next    = cmd.now_ms;
                        end
                        lrcs_pkg::OP_STOP:
                        begin
                            running_next = 1'b0;
                        end
                        lrcs_pkg::OP_UPDATE:
                        begin
                            if (upd_go)
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = elapsed;
                                div_req.divisor  = period_reg;
                                state_next       = S_STEPS;
                            end
                        end
                        lrcs_pkg::OP_RENDER:
                        begin
                            if (rnd_go)
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = {26'd0, head_reg};
                                div_req.divisor  = {9'd0, ring_n};
                                state_next       = S_RHEAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_STEPS:
            begin
                if (div_rsp.done)
                begin
                    // A step count that truncates to zero leaves the time base alone but
                    // still folds the head into the current ring.
                    steps_next = div_rsp.quotient[15:0];
                    state_next = S_TIME;
                end
            end
            S_TIME:
            begin
                last_next        = last_reg + advance;
                div_req.start    = 1'b1;
                div_req.dividend = {26'd0, head_reg};
                div_req.divisor  = {9'd0, ring_n};
                state_next       = S_HMOD;
            end
            S_HMOD:
            begin
                if (div_rsp.done)
                begin
                    hmod_next        = div_rsp.remainder[5:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = {16'd0, steps_reg};
                    div_req.divisor  = {9'd0, ring_n};
                    state_next       = S_SMOD;
                end
            end
            S_SMOD:
            begin
                if (div_rsp.done)
                begin
                    head_next  = new_head[5:0];
                    state_next = S_IDLE;
                end
            end
            S_RHEAD:
            begin
                if (div_rsp.done)
                begin
                    hmod_next        = div_rsp.remainder[5:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = {24'd0, i_start};
                    div_req.divisor  = {9'd0, ring_n};
                    state_next       = S_RSTART;
                end
            end
            S_RSTART:
            begin
                if (div_rsp.done)
                begin
                    r0_next      = div_rsp.remainder[5:0];
                    pix_cnt_next = '0;
                    state_next   = S_PDIM;
                end
            end
            S_PDIM:
            begin
                // Unlit pixels get zero brightness, which scales to black.
                dim_next   = lit ? lrcs_pkg::FULL_BRIGHT - fall_prod[7:0] : 8'd0;
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                state_next = S_PEMIT;
            end
            S_PEMIT:
            begin
                if (pix_free)
                begin
                    pix_valid_next       = 1'b1;
                    pix_next.pixel_index = pix_cnt_reg;
                    pix_next.red         = lrcs_pkg::div255(prod_r_reg);
                    pix_next.green       = lrcs_pkg::div255(prod_g_reg);
                    pix_next.blue        = lrcs_pkg::div255(prod_b_reg);
                    pix_next.last_pixel  = ({1'b0, pix_cnt_reg} + 7'd1) == ring_n;
                    pix_cnt_next         = pix_cnt_reg + 6'd1;
                    state_next           = pix_next.last_pixel ? S_IDLE : S_PDIM;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            running_reg   <= 1'b0;
            head_reg      <= '0;
            last_reg      <= '0;
            pix_cnt_reg   <= '0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            head_reg      <= head_next;
            last_reg      <= last_next;
            pix_cnt_reg   <= pix_cnt_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // Configuration registers; the user writes them only while idle (not enforced).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= lrcs_pkg::RST_LED_COUNT;
            period_reg    <= lrcs_pkg::RST_STEP_PERIOD;
            clockwise_reg <= lrcs_pkg::RST_CLOCKWISE;
            tail_len_reg  <= lrcs_pkg::RST_TAIL_LENGTH;
            falloff_reg   <= lrcs_pkg::RST_TAIL_FALLOFF;
            red_reg       <= lrcs_pkg::RST_COLOR;
            green_reg     <= lrcs_pkg::RST_COLOR;
            blue_reg      <= lrcs_pkg::RST_COLOR;
        end
        else if (cfg_we)
        begin
            unique case (lrcs_pkg::reg_idx_t'(cfg_index))
                lrcs_pkg::REG_LED_COUNT:    led_count_reg <= cfg_data[6:0];
                lrcs_pkg::REG_STEP_PERIOD:  period_reg    <= cfg_data;
                lrcs_pkg::REG_CLOCKWISE:    clockwise_reg <= cfg_data[0];
                lrcs_pkg::REG_TAIL_LENGTH:  tail_len_reg  <= cfg_data[7:0];
                lrcs_pkg::REG_TAIL_FALLOFF: falloff_reg   <= cfg_data[7:0];
                lrcs_pkg::REG_COLOR_RED:    red_reg       <= cfg_data[7:0];
                lrcs_pkg::REG_COLOR_GREEN:  green_reg     <= cfg_data[7:0];
                lrcs_pkg::REG_COLOR_BLUE:   blue_reg      <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg  <= steps_next;
        hmod_reg   <= hmod_next;
        r0_reg     <= r0_next;
        dim_reg    <= dim_next;
        pix_reg    <= pix_next;
        prod_r_reg <= {8'd0, red_reg} * {8'd0, dim_reg};
        prod_g_reg <= {8'd0, green_reg} * {8'd0, dim_reg};
        prod_b_reg <= {8'd0, blue_reg} * {8'd0, dim_reg};
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    // A render accepted while running on a non-empty ring always starts a frame.
    a_render_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (cmd.operation == lrcs_pkg::OP_RENDER) && rnd_go)
        |=> (state_reg == S_RHEAD))
        else $error("render accepted but no frame started");

    // Every pixel sent lies inside the current ring.
    a_pixel_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> ({1'b0, pix.pixel_index} < ring_n))
        else $error("pixel index outside the ring");

    // The head always lands inside the ring after an update.
    a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SMOD && div_rsp.done) |=> ({1'b0, head_reg} < ring_n))
        else $error("head left outside the ring after update");

    // The divider only reports completion to a state that is waiting for it.
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_STEPS || state_reg == S_HMOD
                          || state_reg == S_SMOD || state_reg == S_RHEAD
                          || state_reg == S_RSTART))
        else $error("divider result arrived with no state waiting");

endmodule
